>>> src/swc_pkg.sv
// Shared types, constants and helper functions of the sliding window convolution block.
package swc_pkg;

  localparam int KMAX       = 7;
  localparam int LINES      = (KMAX > 1) ? KMAX - 1 : 1;
  localparam int NCOEF      = KMAX * KMAX;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int POS_W      = 10;
  localparam int DIM_W      = 11;
  localparam int KDIM_W     = 3;
  localparam int IDX_W      = 6;
  localparam int BANK_W     = 3;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_KROWS  = 2'd2;
  localparam logic [1:0] REG_KCOLS  = 2'd3;

  typedef struct packed {
    logic             op;
    logic [IDX_W-1:0] coef_index;
    logic [7:0]       data_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       sum_low8;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic             frame_last;
  } out_item_t;

  typedef struct packed {
    logic              op;
    logic [IDX_W-1:0]  coef_index;
    logic [7:0]        data_value;
    logic [POS_W-1:0]  col;
    logic [BANK_W-1:0] bank;
    logic              emit;
    logic [POS_W-1:0]  res_row;
    logic [POS_W-1:0]  res_col;
    logic              last;
  } work_t;

  typedef struct packed {
    logic [DIM_W-1:0]  image_width;
    logic [DIM_W-1:0]  image_height;
    logic [KDIM_W-1:0] kernel_rows;
    logic [KDIM_W-1:0] kernel_cols;
  } cfg_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

  function automatic logic [KDIM_W-1:0] clamp_k(input logic [KDIM_W-1:0] v);
    logic [KDIM_W-1:0] r;
    r = v;
    if (v == '0) r = KDIM_W'(1);
    else if (32'(v) > KMAX) r = KDIM_W'(KMAX);
    return r;
  endfunction

endpackage

>>> src/swc_front.sv
// Front end: accepts items, tracks the pixel position and classifies each item.
module swc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  swc_pkg::in_item_t in_data,
  output logic             in_stall,
  input  swc_pkg::cfg_t    cfg,
  input  logic             q_full,
  output logic             push,
  output swc_pkg::work_t   push_data
);

  logic [swc_pkg::POS_W-1:0]  row_r, row_nxt, col_r, col_nxt;
  logic [swc_pkg::BANK_W-1:0] bank_r, bank_nxt;
  logic [swc_pkg::DIM_W-1:0]  w_eff, h_eff, r0, c0, r1, c1;
  logic [swc_pkg::BANK_W-1:0] b0, b1;
  logic [swc_pkg::KDIM_W-1:0] kr, kc;
  logic                       is_pixel;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;
  assign is_pixel = (in_data.op == swc_pkg::OP_PIXEL);

  always_comb begin
    w_eff = swc_pkg::clamp_dim(cfg.image_width, swc_pkg::DIM_W'(swc_pkg::MAX_WIDTH));
    h_eff = swc_pkg::clamp_dim(cfg.image_height, swc_pkg::DIM_W'(swc_pkg::MAX_HEIGHT));
    kr    = swc_pkg::clamp_k(cfg.kernel_rows);
    kc    = swc_pkg::clamp_k(cfg.kernel_cols);
    r0    = swc_pkg::DIM_W'(row_r);
    c0    = swc_pkg::DIM_W'(col_r);
    b0    = bank_r;
    if (c0 >= w_eff) begin
      c0 = '0;
      r0 = r0 + 1'b1;
      b0 = (32'(b0) == swc_pkg::LINES - 1) ? '0 : b0 + 1'b1;
    end
    if (r0 >= h_eff) begin
      r0 = '0;
      b0 = '0;
    end
    c1 = c0 + 1'b1;
    r1 = r0;
    b1 = b0;
    if (c1 >= w_eff) begin
      c1 = '0;
      r1 = r0 + 1'b1;
      b1 = (32'(b0) == swc_pkg::LINES - 1) ? '0 : b0 + 1'b1;
      if (r1 >= h_eff) begin
        r1 = '0;
        b1 = '0;
      end
    end
    row_nxt  = swc_pkg::POS_W'(r1);
    col_nxt  = swc_pkg::POS_W'(c1);
    bank_nxt = b1;

    push_data.op         = in_data.op;
    push_data.coef_index = in_data.coef_index;
    push_data.data_value = in_data.data_value;
    push_data.col        = swc_pkg::POS_W'(c0);
    push_data.bank       = b0;
    push_data.emit       = is_pixel && (r0 + 1'b1 >= swc_pkg::DIM_W'(kr)) &&
                           (c0 + 1'b1 >= swc_pkg::DIM_W'(kc));
    push_data.res_row    = swc_pkg::POS_W'(r0 + 1'b1 - swc_pkg::DIM_W'(kr));
    push_data.res_col    = swc_pkg::POS_W'(c0 + 1'b1 - swc_pkg::DIM_W'(kc));
    push_data.last       = (r0 + 1'b1 == h_eff) && (c0 + 1'b1 == w_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      bank_r <= '0;
    end else if (push && is_pixel) begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      bank_r <= bank_nxt;
    end
  end

endmodule

>>> src/swc_queue.sv
// Short queue that decouples the front end from the compute pipeline.
module swc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  swc_pkg::work_t push_data,
  output logic           full,
  input  logic           pop,
  output swc_pkg::work_t pop_data,
  output logic           empty
);

  swc_pkg::work_t               slot_r [swc_pkg::QDEPTH];
  logic [swc_pkg::QPTR_W-1:0]   wr_r, rd_r;
  logic [swc_pkg::QCNT_W-1:0]   cnt_r;

  assign full     = (32'(cnt_r) == swc_pkg::QDEPTH);
  assign empty    = (cnt_r == '0);
  assign pop_data = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop) rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + swc_pkg::QCNT_W'(push) - swc_pkg::QCNT_W'(pop);
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue popped while empty");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= swc_pkg::QDEPTH)
    else $error("queue count beyond depth");

endmodule

>>> src/swc_back.sv
// Back end: line store, window shift, kernel multiply and sum pipeline with output register.
module swc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  swc_pkg::cfg_t     cfg,
  input  logic              q_empty,
  input  swc_pkg::work_t    q_data,
  output logic              pop,
  output logic              out_valid,
  output swc_pkg::out_item_t out_data,
  input  logic              out_stall
);

  localparam int K = swc_pkg::KMAX;

  logic                 en;
  logic                 s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, out_valid_r;
  swc_pkg::work_t       s1_w_r, s2_w_r, s3_w_r, s4_w_r;
  logic [7:0]           line_mem [swc_pkg::LINES][swc_pkg::MAX_WIDTH];
  logic [7:0]           rd_r    [swc_pkg::LINES];
  logic [7:0]           win_r   [K][K];
  logic [7:0]           kern_r  [swc_pkg::NCOEF];
  logic [7:0]           prod_r  [K][K];
  logic [7:0]           rsum_r  [K];
  logic [7:0]           col_new [K];
  logic [7:0]           prod_nxt [K][K];
  logic [7:0]           rsum_nxt [K];
  logic [7:0]           total;
  logic [swc_pkg::KDIM_W-1:0] kr, kc;
  swc_pkg::out_item_t   out_r;

  assign en        = !out_valid_r || !out_stall;
  assign pop       = en && !q_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign kr        = swc_pkg::clamp_k(cfg.kernel_rows);
  assign kc        = swc_pkg::clamp_k(cfg.kernel_cols);

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int b = 0; b < swc_pkg::LINES; b++) begin
        if (q_data.op == swc_pkg::OP_PIXEL && 32'(q_data.bank) == b)
          line_mem[b][q_data.col] <= q_data.data_value;
        rd_r[b] <= line_mem[b][q_data.col];
      end
    end
  end

  always_comb begin
    logic [swc_pkg::BANK_W:0] s;
    for (int h = 0; h < K - 1; h++) begin
      s = {1'b0, s1_w_r.bank} + (swc_pkg::BANK_W + 1)'(h);
      if (32'(s) >= swc_pkg::LINES) s = s - (swc_pkg::BANK_W + 1)'(swc_pkg::LINES);
      col_new[h] = rd_r[s[swc_pkg::BANK_W-1:0]];
    end
    col_new[K-1] = s1_w_r.data_value;
  end

  always_comb begin
    logic [3:0]  ri, ci;
    logic [15:0] p;
    for (int h = 0; h < K; h++) begin
      for (int w = 0; w < K; w++) begin
        ri = 4'(K) - 4'(kr) + 4'(h);
        ci = 4'(K) - 4'(kc) + 4'(w);
        p  = '0;
        if (32'(h) < 32'(kr) && 32'(w) < 32'(kc))
          p = 16'(kern_r[h*K + w]) * 16'(win_r[ri[2:0]][ci[2:0]]);
        prod_nxt[h][w] = p[7:0];
      end
    end
  end

  always_comb begin
    for (int h = 0; h < K; h++) begin
      rsum_nxt[h] = '0;
      for (int w = 0; w < K; w++) rsum_nxt[h] = rsum_nxt[h] + prod_r[h][w];
    end
    total = '0;
    for (int h = 0; h < K; h++) total = total + rsum_r[h];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      s4_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < swc_pkg::NCOEF; i++) kern_r[i] <= '0;
    end else if (en) begin
      s1_vld_r    <= !q_empty;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      s4_vld_r    <= s3_vld_r;
      out_valid_r <= s4_vld_r && s4_w_r.emit;
      if (s2_vld_r && s2_w_r.op == swc_pkg::OP_LOAD &&
          32'(s2_w_r.coef_index) < swc_pkg::NCOEF)
        kern_r[s2_w_r.coef_index] <= s2_w_r.data_value;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (pop) s1_w_r <= q_data;
      s2_w_r <= s1_w_r;
      s3_w_r <= s2_w_r;
      s4_w_r <= s3_w_r;
      if (s1_vld_r && s1_w_r.op == swc_pkg::OP_PIXEL) begin
        for (int h = 0; h < K; h++) begin
          for (int w = 0; w < K - 1; w++) win_r[h][w] <= win_r[h][w+1];
          win_r[h][K-1] <= col_new[h];
        end
      end
      prod_r <= prod_nxt;
      rsum_r <= rsum_nxt;
      if (s4_vld_r && s4_w_r.emit) begin
        out_r.sum_low8   <= total;
        out_r.out_row    <= s4_w_r.res_row;
        out_r.out_col    <= s4_w_r.res_col;
        out_r.frame_last <= s4_w_r.last;
      end
    end
  end

  a_emit_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    en && s4_vld_r && s4_w_r.emit |=> out_valid_r)
    else $error("result lost at output register");
  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(s1_vld_r) && $stable(s4_vld_r))
    else $error("pipeline moved while stalled");

endmodule

>>> src/u8_sliding_window_convolution.sv
// Top level of the 8-bit sliding window convolution block with its register port.
// A pixel item's result passes the queue, stages s1 to s4 and the output register.
// Throughput: one item per cycle; the front end and compute pipeline run in lockstep
// unless the result side stalls, when a 4-entry queue absorbs the front end.
// Reset clears position, kernel coefficients, queue and pipeline valid bits; line
// store and window registers hold no reset value and are filled by pixels.
module u8_sliding_window_convolution (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  swc_pkg::in_item_t  in_data,
  output logic               in_stall,
  output logic               out_valid,
  output swc_pkg::out_item_t out_data,
  input  logic               out_stall,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  swc_pkg::cfg_t  cfg_r;
  swc_pkg::work_t push_data, pop_data;
  logic           push, pop, q_full, q_empty;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= swc_pkg::DIM_W'(48);
      cfg_r.image_height <= swc_pkg::DIM_W'(5);
      cfg_r.kernel_rows  <= swc_pkg::KDIM_W'(3);
      cfg_r.kernel_cols  <= swc_pkg::KDIM_W'(3);
    end else if (wr_en) begin
      unique case (paddr[3:2])
        swc_pkg::REG_WIDTH:  cfg_r.image_width  <= pwdata[swc_pkg::DIM_W-1:0];
        swc_pkg::REG_HEIGHT: cfg_r.image_height <= pwdata[swc_pkg::DIM_W-1:0];
        swc_pkg::REG_KROWS:  cfg_r.kernel_rows  <= pwdata[swc_pkg::KDIM_W-1:0];
        swc_pkg::REG_KCOLS:  cfg_r.kernel_cols  <= pwdata[swc_pkg::KDIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      swc_pkg::REG_WIDTH:  prdata = 32'(cfg_r.image_width);
      swc_pkg::REG_HEIGHT: prdata = 32'(cfg_r.image_height);
      swc_pkg::REG_KROWS:  prdata = 32'(cfg_r.kernel_rows);
      swc_pkg::REG_KCOLS:  prdata = 32'(cfg_r.kernel_cols);
      default:             prdata = '0;
    endcase
  end

  swc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_data(in_data),
    .in_stall(in_stall), .cfg(cfg_r), .q_full(q_full), .push(push),
    .push_data(push_data)
  );

  swc_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data), .full(q_full),
    .pop(pop), .pop_data(pop_data), .empty(q_empty)
  );

  swc_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .q_empty(q_empty), .q_data(pop_data),
    .pop(pop), .out_valid(out_valid), .out_data(out_data), .out_stall(out_stall)
  );

endmodule
